// File: rtl/core/sfse_pkg.sv
package sfse_pkg;

    // opcodes
    localparam logic [7:0] OP_WRITE = 8'h02;
    localparam logic [7:0] OP_READ  = 8'h03;
    localparam logic [7:0] OP_RDSR  = 8'h05;
    localparam logic [7:0] OP_WREN  = 8'h06;
    localparam logic [7:0] OP_RDID  = 8'h9F;

    localparam logic [7:0] ERASED_BYTE = 8'hFF;
    // status byte with the write-enable latch set
    localparam logic [7:0] STATUS_WEL  = 8'h02;

    localparam int         ID_LEN  = 9;
    localparam logic [3:0] ID_LAST = 4'(ID_LEN - 1);

    typedef struct packed {
        logic rd;
        logic wr;
    } t_mem_req;

    function automatic logic [7:0] f_id_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd4: b = 8'h7F;
            4'd5: b = 8'hC2;
            4'd6: b = 8'h00;
            4'd7: b = 8'h26;
            4'd8: b = 8'h08;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: rtl/core/sfse_mem.sv
module sfse_mem #(
    parameter int MEM_BYTES = 524288
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  sfse_pkg::t_mem_req          i_req,
    input  logic [$clog2(MEM_BYTES)-1:0] i_addr,
    input  logic [7:0]                  i_wdata,
    output logic [7:0]                  o_rdata,
    output logic                        o_busy
);
    import sfse_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);

    logic [7:0]    r_mem [MEM_BYTES];
    logic [7:0]    r_rdata;
    logic [AW-1:0] r_clr_addr;
    logic          r_busy;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    // erase sweep after reset, one byte a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(MEM_BYTES - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_comb begin
        wr_en   = r_busy | i_req.wr;
        wr_addr = r_busy ? r_clr_addr : i_addr;
        wr_data = r_busy ? ERASED_BYTE : i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_busy;

`ifndef SYNTHESIS
    a_no_access_while_erasing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.wr || i_req.rd) |-> !r_busy)
        else $error("memory access during erase sweep");
`endif

endmodule

// File: rtl/core/sfse_ctrl.sv
module sfse_ctrl #(
    parameter int MEM_BYTES  = 524288,
    parameter int ADDR_BYTES = 3
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic                         i_mode,
    input  logic [7:0]                   i_data,
    output logic [7:0]                   o_byte,
    output sfse_pkg::t_mem_req           o_req,
    output logic [$clog2(MEM_BYTES)-1:0] o_addr
);
    import sfse_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    localparam int CW = $clog2(ADDR_BYTES);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ID,
        S_STATUS,
        S_RADDR,
        S_RDATA,
        S_WADDR,
        S_WDATA
    } t_phase;

    t_phase        r_phase, n_phase;
    logic          r_latch, n_latch;
    logic [AW-1:0] r_addr,  n_addr;
    logic [CW-1:0] r_cnt,   n_cnt;
    logic [3:0]    r_idx,   n_idx;

    logic [AW-1:0] addr_inc;

    // residue of an address byte at weight 2^8 and 2^16, modulo the memory size
    logic [AW-1:0] pos1_mod [256];
    logic [AW-1:0] pos2_mod [256];
    logic [1:0]    addr_pos;
    logic [AW-1:0] addr_term;
    logic [AW:0]   addr_sum;
    logic [AW-1:0] addr_fold;

    for (genvar g = 0; g < 256; g = g + 1) begin : g_pos_mod
        assign pos1_mod[g] = AW'((longint'(g) * 256) % MEM_BYTES);
        assign pos2_mod[g] = AW'((longint'(g) * 65536) % MEM_BYTES);
    end

    // add the byte's residue at its weight, one conditional subtract keeps it in range
    always_comb begin
        addr_pos = 2'(ADDR_BYTES - 1) - 2'(r_cnt);
        case (addr_pos)
            2'd2:    addr_term = pos2_mod[i_data];
            2'd1:    addr_term = pos1_mod[i_data];
            default: addr_term = AW'(i_data);
        endcase
        addr_sum  = {1'b0, r_addr} + {1'b0, addr_term};
        addr_fold = (addr_sum >= (AW+1)'(MEM_BYTES)) ?
                    AW'(addr_sum - (AW+1)'(MEM_BYTES)) : addr_sum[AW-1:0];
    end

    assign addr_inc = (r_addr == AW'(MEM_BYTES - 1)) ? '0 : r_addr + 1'b1;

    always_comb begin
        n_phase = r_phase;
        n_latch = r_latch;
        n_addr  = r_addr;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        o_byte  = '0;
        o_req   = '0;
        if (i_step) begin
            if (i_mode) begin
                // chip-select release
                if (r_phase == S_WDATA) begin
                    n_latch = 1'b0;
                end
                n_phase = S_IDLE;
                n_addr  = '0;
                n_cnt   = '0;
                n_idx   = '0;
            end else begin
                case (r_phase)
                    S_IDLE: begin
                        n_addr = '0;
                        n_cnt  = '0;
                        n_idx  = '0;
                        case (i_data)
                            OP_RDID:  n_phase = S_ID;
                            OP_RDSR:  n_phase = S_STATUS;
                            OP_WREN:  n_latch = 1'b1;
                            OP_READ:  n_phase = S_RADDR;
                            OP_WRITE: n_phase = S_WADDR;
                            default:  n_phase = S_IDLE;
                        endcase
                    end
                    S_ID: begin
                        o_byte = f_id_byte(r_idx);
                        if (r_idx == ID_LAST) begin
                            n_phase = S_IDLE;
                            n_idx   = '0;
                        end else begin
                            n_idx = r_idx + 1'b1;
                        end
                    end
                    S_STATUS: begin
                        o_byte = r_latch ? STATUS_WEL : '0;
                    end
                    S_RADDR, S_WADDR: begin
                        n_addr = addr_fold;
                        if (r_cnt == CW'(ADDR_BYTES - 1)) begin
                            n_cnt   = '0;
                            n_phase = (r_phase == S_RADDR) ? S_RDATA : S_WDATA;
                        end else begin
                            n_cnt = r_cnt + 1'b1;
                        end
                    end
                    S_RDATA: begin
                        o_req.rd = 1'b1;
                        n_addr   = addr_inc;
                    end
                    S_WDATA: begin
                        // dropped without advancing when write is disabled
                        if (r_latch) begin
                            o_req.wr = 1'b1;
                            n_addr   = addr_inc;
                        end
                    end
                    default: begin
                        n_phase = S_IDLE;
                        n_addr  = '0;
                        n_cnt   = '0;
                        n_idx   = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= S_IDLE;
            r_latch <= 1'b0;
            r_addr  <= '0;
            r_cnt   <= '0;
            r_idx   <= '0;
        end else begin
            r_phase <= n_phase;
            r_latch <= n_latch;
            r_addr  <= n_addr;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
        end
    end

    assign o_addr = r_addr;

`ifndef SYNTHESIS
    a_rd_wr_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_req.rd && o_req.wr))
        else $error("read and write requested together");

    a_release_goes_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_mode) |=> (r_phase == S_IDLE && r_idx == '0 && r_cnt == '0))
        else $error("session not cleared after release");

    a_latch_falls_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_latch) |-> ($past(i_step && i_mode) || $past(!i_rst_n)))
        else $error("write enable cleared without release");
`endif

endmodule

// File: rtl/core/spi_fram_slave_engine_unit.sv
// Serial FRAM slave: each transfer in is one exchanged SPI byte or a chip-select
// release, and each gives exactly one byte back. One transfer is accepted per
// clock unless the erase sweep runs or the output is stalled; its result passes
// through the input register, then the result register or the registered memory
// read port. The byte array is a synchronous RAM of MEM_BYTES bytes with one
// write port and one registered read port. After reset it is erased to 0xFF by a
// sweep, one byte a cycle, with o_in_ready low. Address bytes are folded modulo
// MEM_BYTES as they arrive, so data streaming starts after the last address byte.
module spi_fram_slave_engine_unit #(
    parameter int MEM_BYTES  = 524288,
    parameter int ADDR_BYTES = 3
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_mode,
    input  logic [7:0] i_data_in,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_data_out
);
    import sfse_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);

    logic          r_s1_valid;
    logic          r_mode;
    logic [7:0]    r_data;
    logic          r_out_valid;
    logic          r_sel_mem;
    logic [7:0]    r_byte;

    logic          s1_step;
    logic          in_xfer;
    logic          busy;
    logic [7:0]    ctrl_byte;
    t_mem_req      mem_req;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_rdata;

    assign s1_step    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !busy && (!r_s1_valid || s1_step);
    assign in_xfer    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_step) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_mode <= i_mode;
            r_data <= i_data_in;
        end
        if (s1_step) begin
            r_byte    <= ctrl_byte;
            r_sel_mem <= mem_req.rd;
        end
    end

    sfse_ctrl #(
        .MEM_BYTES  (MEM_BYTES),
        .ADDR_BYTES (ADDR_BYTES)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (s1_step),
        .i_mode  (r_mode),
        .i_data  (r_data),
        .o_byte  (ctrl_byte),
        .o_req   (mem_req),
        .o_addr  (mem_addr)
    );

    sfse_mem #(
        .MEM_BYTES (MEM_BYTES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .i_addr  (mem_addr),
        .i_wdata (r_data),
        .o_rdata (mem_rdata),
        .o_busy  (busy)
    );

    assign o_out_valid = r_out_valid;
    assign o_data_out  = r_sel_mem ? mem_rdata : r_byte;

`ifndef SYNTHESIS
    a_no_item_while_erasing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> !busy)
        else $error("transfer held in input stage during erase sweep");
`endif

endmodule
